/* rtl/irpcf_pkg.sv */
// ----------------------------------------------------------------------------
// irpcf_pkg
// Shared types, constants and tables of the roll/pitch complementary filter.
// ----------------------------------------------------------------------------
package irpcf_pkg;

    // Default sizes
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int ANGLE_WIDTH_DEF  = 32;
    localparam int CORDIC_STEPS_DEF = 24;

    // Fixed-point formats
    localparam int ACCEL_PRESHIFT = 8;      // accel scaled up before atan2
    localparam int Z_W            = 28;     // CORDIC angle, rad * 2^24
    localparam int ML_W           = 24;     // serial multiplier operand width
    localparam int ALPHA_W        = 17;
    localparam int GAIN_W         = 24;
    localparam int APB_AW         = 3;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'd65536;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd62259;
    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 24'd45700;

    localparam logic signed [Z_W-1:0] HALF_PI_Q24 = 28'sd26353589;
    localparam logic signed [63:0]    GYRO_LIMIT  = 64'sh0000_7FFF_FFFF_FFFF;

    // Register indexes
    localparam logic REG_ALPHA = 1'b0;
    localparam logic REG_GAIN  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SQ_Y,
        S_SQ_Z,
        S_SQRT,
        S_ROLL_ATAN,
        S_PITCH_ATAN,
        S_ROLL_GYRO,
        S_ROLL_BLEND,
        S_PITCH_GYRO,
        S_PITCH_BLEND,
        S_DONE
    } state_t;

    // atan(2^-i) in rad * 2^24
    function automatic logic [Z_W-1:0] atan_q24(input logic [4:0] idx);
        logic [Z_W-1:0] v;
        case (idx)
            5'd0:    v = 28'd13176795;
            5'd1:    v = 28'd7778716;
            5'd2:    v = 28'd4110060;
            5'd3:    v = 28'd2086331;
            5'd4:    v = 28'd1047214;
            5'd5:    v = 28'd524117;
            5'd6:    v = 28'd262123;
            5'd7:    v = 28'd131069;
            5'd8:    v = 28'd65536;
            5'd9:    v = 28'd32768;
            5'd10:   v = 28'd16384;
            5'd11:   v = 28'd8192;
            5'd12:   v = 28'd4096;
            5'd13:   v = 28'd2048;
            5'd14:   v = 28'd1024;
            5'd15:   v = 28'd512;
            5'd16:   v = 28'd256;
            5'd17:   v = 28'd128;
            5'd18:   v = 28'd64;
            5'd19:   v = 28'd32;
            5'd20:   v = 28'd16;
            5'd21:   v = 28'd8;
            5'd22:   v = 28'd4;
            5'd23:   v = 28'd2;
            5'd24:   v = 28'd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

/* rtl/irpcf_in_if.sv */
// ----------------------------------------------------------------------------
// irpcf_in_if
// Input channel: one IMU sample per item.
// ----------------------------------------------------------------------------
interface irpcf_in_if #(
    parameter int SAMPLE_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] gyro_x;
    logic signed [SAMPLE_WIDTH-1:0] gyro_y;
    logic signed [SAMPLE_WIDTH-1:0] accel_x;
    logic signed [SAMPLE_WIDTH-1:0] accel_y;
    logic signed [SAMPLE_WIDTH-1:0] accel_z;

    modport source (output valid, gyro_x, gyro_y, accel_x, accel_y, accel_z, input ready);
    modport sink   (input valid, gyro_x, gyro_y, accel_x, accel_y, accel_z, output ready);
endinterface

/* rtl/irpcf_out_if.sv */
// ----------------------------------------------------------------------------
// irpcf_out_if
// Output channel: roll and pitch estimates, one item per sample.
// ----------------------------------------------------------------------------
interface irpcf_out_if #(
    parameter int ANGLE_WIDTH = 32
);
    logic                          valid;
    logic                          ready;
    logic signed [ANGLE_WIDTH-1:0] roll_angle;
    logic signed [ANGLE_WIDTH-1:0] pitch_angle;

    modport source (output valid, roll_angle, pitch_angle, input ready);
    modport sink   (input valid, roll_angle, pitch_angle, output ready);
endinterface

/* rtl/irpcf_smul.sv */
// ----------------------------------------------------------------------------
// irpcf_smul
// Bit-serial shift-add multiplier: signed multiplicand times unsigned
// multiplier, one multiplier bit per cycle, LSB first.
// ----------------------------------------------------------------------------
module irpcf_smul
    import irpcf_pkg::*;
#(
    parameter int MC_W = 48
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic signed [MC_W-1:0]       mcand,
    input  logic [ML_W-1:0]              mplier,
    output logic                         done,
    output logic signed [MC_W+ML_W-1:0]  product
);
    localparam int P_W   = MC_W + ML_W;
    localparam int CNT_W = $clog2(ML_W);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic signed [P_W-1:0] mc_reg, mc_next;
    logic [ML_W-1:0]       ml_reg, ml_next;
    logic signed [P_W-1:0] acc_reg, acc_next;
    logic                  last;

    assign last = (cnt_reg == CNT_W'(ML_W - 1));

    // One partial product a cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        mc_next   = mc_reg;
        ml_next   = ml_reg;
        acc_next  = acc_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            mc_next   = P_W'(mcand);
            ml_next   = mplier;
            acc_next  = '0;
        end
        else if (busy_reg)
        begin
            if (ml_reg[0])
            begin
                acc_next = acc_reg + mc_reg;
            end
            mc_next  = mc_reg <<< 1;
            ml_next  = ml_reg >> 1;
            cnt_next = cnt_reg + CNT_W'(1);
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mc_reg  <= mc_next;
        ml_reg  <= ml_next;
        acc_reg <= acc_next;
    end

    assign done    = done_reg;
    assign product = acc_reg;
endmodule

/* rtl/irpcf_cordic.sv */
// ----------------------------------------------------------------------------
// irpcf_cordic
// Iterative vectoring CORDIC atan2(y, x), one micro-rotation per cycle,
// with a quarter-turn pre-rotation for negative x.
// ----------------------------------------------------------------------------
module irpcf_cordic
    import irpcf_pkg::*;
#(
    parameter int CV_W         = 28,
    parameter int CORDIC_STEPS = 24
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  logic signed [CV_W-1:0] y_in,
    input  logic signed [CV_W-1:0] x_in,
    output logic                   done,
    output logic signed [Z_W-1:0]  angle
);
    localparam int CNT_W = $clog2(CORDIC_STEPS);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   zero_reg, zero_next;
    logic signed [CV_W-1:0] x_reg, x_next;
    logic signed [CV_W-1:0] y_reg, y_next;
    logic signed [Z_W-1:0]  z_reg, z_next;
    logic signed [CV_W-1:0] dx, dy;
    logic signed [Z_W-1:0]  step_ang;

    assign dx       = y_reg >>> cnt_reg;
    assign dy       = x_reg >>> cnt_reg;
    assign step_ang = $signed(atan_q24(5'(cnt_reg)));

    // Load with pre-rotation, then one rotation a cycle
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        zero_next = zero_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        z_next    = z_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            zero_next = (x_in == '0) && (y_in == '0);
            if (x_in < 0)
            begin
                if (y_in >= 0)
                begin
                    x_next = y_in;
                    y_next = -x_in;
                    z_next = HALF_PI_Q24;
                end
                else
                begin
                    x_next = -y_in;
                    y_next = x_in;
                    z_next = -HALF_PI_Q24;
                end
            end
            else
            begin
                x_next = x_in;
                y_next = y_in;
                z_next = '0;
            end
        end
        else if (busy_reg)
        begin
            if (y_reg >= 0)
            begin
                x_next = x_reg + dx;
                y_next = y_reg - dy;
                z_next = z_reg + step_ang;
            end
            else
            begin
                x_next = x_reg - dx;
                y_next = y_reg + dy;
                z_next = z_reg - step_ang;
            end
            cnt_next = cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(CORDIC_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        zero_reg <= zero_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
    end

    assign done  = done_reg;
    assign angle = zero_reg ? '0 : z_reg;
endmodule

/* rtl/imu_roll_pitch_complementary_filter_unit.sv */
// ----------------------------------------------------------------------------
// imu_roll_pitch_complementary_filter_unit
// Roll/pitch complementary filter over one IMU sample per item.
// ----------------------------------------------------------------------------
// One sample is worked at a time. After reset the first item skips the
// sequence and returns zero estimates. Every later item runs a fixed
// sequence on two shared iterative units: six passes of the bit-serial
// multiplier (ay^2, az^2, two gyro rate*gain terms, two alpha blends), two
// CORDIC atan2 passes and an integer square root. The multiplier loop
// takes one bit per cycle. A new item is taken while the previous result
// still waits in the output register.
// ----------------------------------------------------------------------------
module imu_roll_pitch_complementary_filter_unit
    import irpcf_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int ANGLE_WIDTH  = ANGLE_WIDTH_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    irpcf_in_if.sink           in_ch,
    irpcf_out_if.source        out_ch,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    localparam int SW    = SAMPLE_WIDTH;
    localparam int AW    = ANGLE_WIDTH;
    localparam int PRE   = ACCEL_PRESHIFT;
    localparam int CV_W  = SW + PRE + 4;
    localparam int SQS_W = 2 * SW;
    localparam int SQ_W  = 2 * SW + 2 * PRE;
    localparam int RT_W  = SW + PRE;
    localparam int GW    = ((AW > SW + 16) ? AW : SW + 16) + 1;
    localparam int DW    = ((GW > Z_W) ? GW : Z_W) + 1;
    localparam int MC_W  = DW;
    localparam int P_W   = MC_W + ML_W;
    localparam int MIX_W = P_W + 1;

    localparam logic signed [MIX_W-1:0] AMAX = (MIX_W'(1) <<< (AW - 1)) - MIX_W'(1);
    localparam logic signed [MIX_W-1:0] AMIN = -AMAX - MIX_W'(1);

    state_t state_reg, state_next;
    logic   go_reg;

    // Configuration
    logic [ALPHA_W-1:0] alpha_reg;
    logic [GAIN_W-1:0]  gain_reg;
    logic               cfg_wr;

    // Sample and working registers
    logic signed [SW-1:0]   gx_reg, gy_reg, ax_reg, ay_reg, az_reg;
    logic [SQS_W-1:0]       sq_reg;
    logic [SQ_W-1:0]        rem_reg, root_reg, bit_reg;
    logic signed [Z_W-1:0]  roll_acc_reg, pitch_acc_reg;
    logic signed [GW-1:0]   gyro_reg;
    logic signed [AW-1:0]   roll_est_reg, pitch_est_reg;
    logic                   first_seen_reg;
    logic                   out_valid_reg;
    logic signed [AW-1:0]   out_roll_reg, out_pitch_reg;

    // Unit hookup
    logic                   mul_start, mul_done;
    logic signed [MC_W-1:0] mul_mcand;
    logic [ML_W-1:0]        mul_mplier;
    logic signed [P_W-1:0]  mul_prod;
    logic                   cor_start, cor_done;
    logic signed [CV_W-1:0] cor_y, cor_x;
    logic signed [Z_W-1:0]  cor_angle;

    logic                   in_acc, out_free, sqrt_done;
    logic [SW:0]            ay_abs, az_abs;
    logic [SQ_W:0]          sqrt_trial;
    logic [ALPHA_W-1:0]     alpha_eff;
    logic signed [AW-1:0]   est_sel;
    logic signed [Z_W-1:0]  acc_sel;
    logic signed [P_W:0]    gprod_rnd;
    logic signed [GW-1:0]   g_sum;
    logic signed [63:0]     g_wide;
    logic signed [GW-1:0]   g_sat;
    logic signed [MIX_W-1:0] mix;
    logic signed [MIX_W-1:0] mix_rnd;
    logic signed [AW-1:0]   blend_sat;

    assign in_acc    = in_ch.valid && in_ch.ready;
    assign out_free  = !out_valid_reg || out_ch.ready;
    assign sqrt_done = !go_reg && (bit_reg == '0);

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[2])
            REG_ALPHA: prdata = 32'(alpha_reg);
            REG_GAIN:  prdata = 32'(gain_reg);
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= ALPHA_RESET;
            gain_reg  <= GAIN_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_ALPHA: alpha_reg <= pwdata[ALPHA_W-1:0];
                REG_GAIN:  gain_reg  <= pwdata[GAIN_W-1:0];
                default:   ;
            endcase
        end
    end

    // ---------------- sequencer: next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:        if (in_acc) state_next = first_seen_reg ? S_SQ_Y : S_DONE;
            S_SQ_Y:        if (mul_done) state_next = S_SQ_Z;
            S_SQ_Z:        if (mul_done) state_next = S_SQRT;
            S_SQRT:        if (sqrt_done) state_next = S_ROLL_ATAN;
            S_ROLL_ATAN:   if (cor_done) state_next = S_PITCH_ATAN;
            S_PITCH_ATAN:  if (cor_done) state_next = S_ROLL_GYRO;
            S_ROLL_GYRO:   if (mul_done) state_next = S_ROLL_BLEND;
            S_ROLL_BLEND:  if (mul_done) state_next = S_PITCH_GYRO;
            S_PITCH_GYRO:  if (mul_done) state_next = S_PITCH_BLEND;
            S_PITCH_BLEND: if (mul_done) state_next = S_DONE;
            S_DONE:        if (out_free) state_next = S_IDLE;
            default:       state_next = S_IDLE;
        endcase
    end

    // ---------------- sequencer: outputs ----------------
    assign ay_abs    = ay_reg[SW-1] ? -(SW+1)'(ay_reg) : (SW+1)'(ay_reg);
    assign az_abs    = az_reg[SW-1] ? -(SW+1)'(az_reg) : (SW+1)'(az_reg);
    assign alpha_eff = alpha_reg[ALPHA_W-1] ? ALPHA_ONE : alpha_reg;

    always_comb
    begin
        in_ch.ready = 1'b0;
        mul_start   = 1'b0;
        mul_mcand   = '0;
        mul_mplier  = '0;
        cor_start   = 1'b0;
        cor_y       = '0;
        cor_x       = '0;
        est_sel     = roll_est_reg;
        acc_sel     = roll_acc_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ch.ready = 1'b1;
            end
            S_SQ_Y:
            begin
                mul_start  = go_reg;
                mul_mcand  = $signed(MC_W'(ay_abs));
                mul_mplier = ML_W'(ay_abs);
            end
            S_SQ_Z:
            begin
                mul_start  = go_reg;
                mul_mcand  = $signed(MC_W'(az_abs));
                mul_mplier = ML_W'(az_abs);
            end
            S_ROLL_ATAN:
            begin
                cor_start = go_reg;
                cor_y     = CV_W'(ay_reg) <<< PRE;
                cor_x     = CV_W'(az_reg) <<< PRE;
            end
            S_PITCH_ATAN:
            begin
                cor_start = go_reg;
                cor_y     = CV_W'(ax_reg) <<< PRE;
                cor_x     = $signed(CV_W'(root_reg[RT_W-1:0]));
            end
            S_ROLL_GYRO:
            begin
                mul_start  = go_reg;
                mul_mcand  = MC_W'(gx_reg);
                mul_mplier = gain_reg;
            end
            S_ROLL_BLEND:
            begin
                mul_start  = go_reg;
                mul_mcand  = DW'(gyro_reg) - DW'(roll_acc_reg);
                mul_mplier = ML_W'(alpha_eff);
            end
            S_PITCH_GYRO:
            begin
                mul_start  = go_reg;
                mul_mcand  = MC_W'(gy_reg);
                mul_mplier = gain_reg;
                est_sel    = pitch_est_reg;
            end
            S_PITCH_BLEND:
            begin
                mul_start  = go_reg;
                mul_mcand  = DW'(gyro_reg) - DW'(pitch_acc_reg);
                mul_mplier = ML_W'(alpha_eff);
                acc_sel    = pitch_acc_reg;
            end
            default: ;
        endcase
    end

    // ---------------- gyro angle and blend arithmetic ----------------
    assign gprod_rnd = ((P_W+1)'(mul_prod) + (P_W+1)'(128)) >>> 8;
    assign g_sum     = GW'(est_sel) + GW'(gprod_rnd);
    assign g_wide    = 64'(g_sum);

    always_comb
    begin
        if (g_wide > GYRO_LIMIT)
            g_sat = GW'(GYRO_LIMIT);
        else if (g_wide < -GYRO_LIMIT)
            g_sat = GW'(-GYRO_LIMIT);
        else
            g_sat = g_sum;
    end

    assign mix     = MIX_W'(mul_prod) + (MIX_W'(acc_sel) <<< 16) + MIX_W'(32768);
    assign mix_rnd = mix >>> 16;

    always_comb
    begin
        if (mix_rnd > AMAX)
            blend_sat = AW'(AMAX);
        else if (mix_rnd < AMIN)
            blend_sat = AW'(AMIN);
        else
            blend_sat = AW'(mix_rnd);
    end

    // ---------------- square root step ----------------
    assign sqrt_trial = (SQ_W+1)'(root_reg) + (SQ_W+1)'(bit_reg);

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            go_reg         <= 1'b0;
            first_seen_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            roll_est_reg   <= '0;
            pitch_est_reg  <= '0;
            bit_reg        <= '0;
        end
        else
        begin
            state_reg <= state_next;
            go_reg    <= (state_next != state_reg);
            if (in_acc)
                first_seen_reg <= 1'b1;
            if (state_reg == S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
            if (state_reg == S_ROLL_BLEND && mul_done)
                roll_est_reg <= blend_sat;
            if (state_reg == S_PITCH_BLEND && mul_done)
                pitch_est_reg <= blend_sat;
            if (state_reg == S_SQRT)
            begin
                if (go_reg)
                    bit_reg <= SQ_W'(1) << (SQ_W - 2);
                else
                    bit_reg <= bit_reg >> 2;
            end
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            gx_reg <= in_ch.gyro_x;
            gy_reg <= in_ch.gyro_y;
            ax_reg <= in_ch.accel_x;
            ay_reg <= in_ch.accel_y;
            az_reg <= in_ch.accel_z;
        end
        if (state_reg == S_SQ_Y && mul_done)
            sq_reg <= SQS_W'(mul_prod);
        if (state_reg == S_SQ_Z && mul_done)
            sq_reg <= sq_reg + SQS_W'(mul_prod);
        if (state_reg == S_SQRT)
        begin
            if (go_reg)
            begin
                rem_reg  <= {sq_reg, (2*PRE)'(0)};
                root_reg <= '0;
            end
            else if (bit_reg != '0)
            begin
                if ((SQ_W+1)'(rem_reg) >= sqrt_trial)
                begin
                    rem_reg  <= rem_reg - SQ_W'(sqrt_trial);
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                begin
                    root_reg <= root_reg >> 1;
                end
            end
        end
        if (state_reg == S_ROLL_ATAN && cor_done)
            roll_acc_reg <= cor_angle;
        if (state_reg == S_PITCH_ATAN && cor_done)
            pitch_acc_reg <= cor_angle;
        if ((state_reg == S_ROLL_GYRO || state_reg == S_PITCH_GYRO) && mul_done)
            gyro_reg <= g_sat;
        if (state_reg == S_DONE && out_free)
        begin
            out_roll_reg  <= roll_est_reg;
            out_pitch_reg <= pitch_est_reg;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.roll_angle  = out_roll_reg;
    assign out_ch.pitch_angle = out_pitch_reg;

    // ---------------- shared units ----------------
    irpcf_smul #(
        .MC_W (MC_W)
    ) u_smul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (mul_mcand),
        .mplier  (mul_mplier),
        .done    (mul_done),
        .product (mul_prod)
    );

    irpcf_cordic #(
        .CV_W         (CV_W),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cor_start),
        .y_in  (cor_y),
        .x_in  (cor_x),
        .done  (cor_done),
        .angle (cor_angle)
    );

    // ---------------- assertions ----------------
    a_est_zero_until_first: assert property (@(posedge clk) disable iff (!rst_n)
        !first_seen_reg |-> (roll_est_reg == '0) && (pitch_est_reg == '0))
        else $error("estimates moved before the first item");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside the done state");

    a_no_unit_clash: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> !cor_done)
        else $error("multiplier and CORDIC finished together");
endmodule
